// File: rtl/core/sld_pkg.sv
// shared types, codes and constants of the serial link receive deframer
`timescale 1ns / 1ps
`default_nettype none
package sld_pkg;

  localparam int BYTE_W    = 8;
  localparam int LEN_W     = 7;
  localparam int IDX_W     = 7;
  localparam int ACT_W     = 2;
  localparam int MODE_W    = 2;
  localparam int CFG_IDX_W = 3;

  localparam int FIXED_FRAME_BYTES_DEF = 12;
  localparam int VAR_FRAME_MAX_DEF     = 124;
  localparam int LEN_SAT               = 127;

  localparam logic [MODE_W-1:0] MODE_OFF    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SINGLE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FIXED  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_VAR    = 2'd3;

  localparam logic [ACT_W-1:0] ACT_BYTE    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_READ    = 2'd1;
  localparam logic [ACT_W-1:0] ACT_RELEASE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIX_START = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FIX_END   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VAR_START = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VAR_END   = 3'd4;

  localparam logic [1:0] SEL_REG = 2'd0;
  localparam logic [1:0] SEL_FIX = 2'd1;
  localparam logic [1:0] SEL_VAR = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [BYTE_W-1:0] fix_start;
    logic [BYTE_W-1:0] fix_end;
    logic [BYTE_W-1:0] var_start;
    logic [BYTE_W-1:0] var_end;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        sel;
    logic [BYTE_W-1:0] data;
    logic [LEN_W-1:0]  frame_length;
    logic              single_rdy;
    logic              fixed_ready;
    logic              var_ready;
    logic              resync;
    logic              error;
    logic              release_done;
  } res_t;

endpackage
`default_nettype wire

// File: rtl/core/sld_ram.sv
// single write port, single read port memory with registered read data
`timescale 1ns / 1ps
`default_nettype none
module sld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/sld_ctrl.sv
// receive state, frame checks, memory access control and result register
`timescale 1ns / 1ps
`default_nettype none
module sld_ctrl #(
  parameter int FIXED_N = sld_pkg::FIXED_FRAME_BYTES_DEF,
  parameter int VAR_MAX = sld_pkg::VAR_FRAME_MAX_DEF,
  localparam int FAW = $clog2(2 * FIXED_N),
  localparam int VAW = $clog2(VAR_MAX)
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire sld_pkg::cfg_t                      cfg,
  input  wire logic                               cfg_clr,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [sld_pkg::ACT_W-1:0]          in_action,
  input  wire logic [sld_pkg::BYTE_W-1:0]         in_rx_byte,
  input  wire logic                               in_rx_error,
  input  wire logic [sld_pkg::IDX_W-1:0]          in_read_index,
  input  wire logic [sld_pkg::IDX_W-1:0]          in_dest_room,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output sld_pkg::res_t                           res,
  output logic                                    fx_we,
  output logic [FAW-1:0]                          fx_waddr,
  output logic                                    fx_re,
  output logic [FAW-1:0]                          fx_raddr,
  output logic                                    vr_we,
  output logic [VAW-1:0]                          vr_waddr,
  output logic                                    vr_re,
  output logic [VAW-1:0]                          vr_raddr
);

  import sld_pkg::*;

  localparam int FCW = $clog2(FIXED_N);
  localparam int CW  = $clog2(VAR_MAX + 1);

  logic [FCW-1:0]    fill_r, fill_nxt;
  logic              fixed_rdy_r, fixed_rdy_nxt;
  logic              resync_r, resync_nxt;
  logic              err_r, err_nxt;
  logic [BYTE_W-1:0] latched_r, latched_nxt;
  logic              byte_rdy_r, byte_rdy_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              coll_r, coll_nxt;
  logic              var_rdy_r, var_rdy_nxt;
  logic              pub_bank_r, pub_bank_nxt;
  logic [BYTE_W-1:0] first_r, first_nxt;
  logic              out_valid_r, out_valid_nxt;
  res_t              res_r, res_nxt;

  logic              acc;
  logic              errp;
  logic [BYTE_W-1:0] first_byte;
  logic [FAW-1:0]    cap_base, pub_base;
  logic [LEN_W-1:0]  len;

  assign in_ready  = !out_valid_r || out_ready;
  assign acc       = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign res       = res_r;

  assign cap_base = pub_bank_r ? '0 : FAW'(FIXED_N);
  assign pub_base = pub_bank_r ? FAW'(FIXED_N) : '0;

  assign errp       = err_r || in_rx_error;
  assign first_byte = (fill_r == '0) ? in_rx_byte : first_r;

  always_comb begin
    fill_nxt      = fill_r;
    fixed_rdy_nxt = fixed_rdy_r;
    resync_nxt    = resync_r;
    err_nxt       = err_r;
    latched_nxt   = latched_r;
    byte_rdy_nxt  = byte_rdy_r;
    cnt_nxt       = cnt_r;
    coll_nxt      = coll_r;
    var_rdy_nxt   = var_rdy_r;
    pub_bank_nxt  = pub_bank_r;
    first_nxt     = first_r;
    fx_we         = 1'b0;
    fx_waddr      = cap_base + FAW'(fill_r);
    fx_re         = 1'b0;
    fx_raddr      = pub_base + FAW'(in_read_index);
    vr_we         = 1'b0;
    vr_waddr      = VAW'(cnt_r);
    vr_re         = 1'b0;
    vr_raddr      = VAW'(in_read_index);
    res_nxt       = res_r;
    res_nxt.sel          = SEL_REG;
    res_nxt.data         = '0;
    res_nxt.release_done = 1'b0;
    unique case (in_action)
      ACT_BYTE: begin
        unique case (cfg.mode)
          MODE_SINGLE: begin
            if (in_rx_error) begin
              err_nxt = 1'b1;
            end else begin
              latched_nxt  = in_rx_byte;
              byte_rdy_nxt = 1'b1;
            end
          end
          MODE_FIXED: begin
            if (resync_r) begin
              if (in_rx_error) begin
                err_nxt = 1'b1;
              end else if (in_rx_byte == cfg.fix_end) begin
                resync_nxt = 1'b0;
                err_nxt    = 1'b0;
              end
            end else begin
              fx_we     = 1'b1;
              first_nxt = first_byte;
              if (int'(fill_r) == FIXED_N - 1) begin
                fill_nxt = '0;
                err_nxt  = 1'b0;
                if (!errp && first_byte == cfg.fix_start && in_rx_byte == cfg.fix_end) begin
                  fixed_rdy_nxt = 1'b1;
                  pub_bank_nxt  = !pub_bank_r;
                end else begin
                  resync_nxt = 1'b1;
                end
              end else begin
                fill_nxt = fill_r + FCW'(1);
                err_nxt  = errp;
              end
            end
          end
          MODE_VAR: begin
            if (in_rx_error) begin
              err_nxt = 1'b1;
            end else if (!var_rdy_r) begin
              if (in_rx_byte == cfg.var_start) begin
                vr_we    = 1'b1;
                vr_waddr = '0;
                cnt_nxt  = CW'(1);
                coll_nxt = 1'b1;
              end else if (coll_r) begin
                if (int'(cnt_r) >= VAR_MAX) begin
                  cnt_nxt  = '0;
                  coll_nxt = 1'b0;
                end else begin
                  vr_we   = 1'b1;
                  cnt_nxt = cnt_r + CW'(1);
                  if (in_rx_byte == cfg.var_end) begin
                    var_rdy_nxt = 1'b1;
                    coll_nxt    = 1'b0;
                  end
                end
              end
            end
          end
          default: begin
          end
        endcase
      end
      ACT_READ: begin
        unique case (cfg.mode)
          MODE_SINGLE: res_nxt.data = latched_r;
          MODE_FIXED: begin
            if (int'(in_read_index) < FIXED_N) begin
              fx_re       = 1'b1;
              res_nxt.sel = SEL_FIX;
            end
          end
          MODE_VAR: begin
            if (int'(in_read_index) < VAR_MAX) begin
              vr_re       = 1'b1;
              res_nxt.sel = SEL_VAR;
            end
          end
          default: begin
          end
        endcase
      end
      ACT_RELEASE: begin
        unique case (cfg.mode)
          MODE_SINGLE: begin
            if (byte_rdy_r) begin
              byte_rdy_nxt         = 1'b0;
              res_nxt.release_done = 1'b1;
            end
          end
          MODE_FIXED: begin
            if (fixed_rdy_r) begin
              fixed_rdy_nxt        = 1'b0;
              res_nxt.release_done = 1'b1;
            end
          end
          MODE_VAR: begin
            if (var_rdy_r && cnt_r != '0 && int'(cnt_r) <= int'(in_dest_room)) begin
              var_rdy_nxt          = 1'b0;
              cnt_nxt              = '0;
              res_nxt.release_done = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase

    if (cfg.mode == MODE_FIXED && fixed_rdy_nxt) begin
      len = LEN_W'(FIXED_N);
    end else if (cfg.mode == MODE_VAR && var_rdy_nxt) begin
      len = (int'(cnt_nxt) > LEN_SAT) ? LEN_W'(LEN_SAT) : LEN_W'(cnt_nxt);
    end else begin
      len = '0;
    end
    res_nxt.frame_length = len;
    res_nxt.single_rdy   = byte_rdy_nxt;
    res_nxt.fixed_ready  = fixed_rdy_nxt;
    res_nxt.var_ready    = var_rdy_nxt;
    res_nxt.resync       = resync_nxt;
    res_nxt.error        = err_nxt;

    if (!acc) begin
      fx_we = 1'b0;
      fx_re = 1'b0;
      vr_we = 1'b0;
      vr_re = 1'b0;
    end

    out_valid_nxt = acc ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      fixed_rdy_r <= 1'b0;
      resync_r    <= 1'b0;
      err_r       <= 1'b0;
      latched_r   <= '0;
      byte_rdy_r  <= 1'b0;
      cnt_r       <= '0;
      coll_r      <= 1'b0;
      var_rdy_r   <= 1'b0;
      pub_bank_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (cfg_clr) begin
      fill_r      <= '0;
      fixed_rdy_r <= 1'b0;
      resync_r    <= 1'b0;
      err_r       <= 1'b0;
      byte_rdy_r  <= 1'b0;
      cnt_r       <= '0;
      coll_r      <= 1'b0;
      var_rdy_r   <= 1'b0;
      out_valid_r <= out_valid_nxt;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (acc) begin
        fill_r      <= fill_nxt;
        fixed_rdy_r <= fixed_rdy_nxt;
        resync_r    <= resync_nxt;
        err_r       <= err_nxt;
        latched_r   <= latched_nxt;
        byte_rdy_r  <= byte_rdy_nxt;
        cnt_r       <= cnt_nxt;
        coll_r      <= coll_nxt;
        var_rdy_r   <= var_rdy_nxt;
        pub_bank_r  <= pub_bank_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      first_r <= first_nxt;
      res_r   <= res_nxt;
    end
  end

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    int'(fill_r) < FIXED_N)
    else $error("fixed fill count out of range");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    int'(cnt_r) <= VAR_MAX)
    else $error("variable count out of range");

  a_ready_not_coll: assert property (@(posedge clk) disable iff (!rst_n)
    var_rdy_r |-> (!coll_r && cnt_r != '0))
    else $error("held variable frame inconsistent");

  a_resync_fill: assert property (@(posedge clk) disable iff (!rst_n)
    resync_r |-> fill_r == '0)
    else $error("capture in progress while resyncing");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> $stable(res_r))
    else $error("result changed while stalled");

endmodule
`default_nettype wire

// File: rtl/core/serial_link_receive_deframer.sv
// top level: configuration registers, control, frame memories and result mux
//
//  port group   direction  transaction
//  cfg_*        in         register write: cfg_index, cfg_wdata
//  in_*         in         action with byte, error, read index and room
//  out_*        out        one result per action: byte, length and flags
//
//  one action accepted per cycle while in_ready is high, result registered on acceptance
//  frame bytes sit in two memories with registered read data
//  the fixed frame memory holds two banks; publishing flips the bank pointer
//  synchronous active-low reset clears all receive state, stored bytes keep
//  in_ready drops only while a result is held by out_ready low
`timescale 1ns / 1ps
`default_nettype none
module serial_link_receive_deframer #(
  parameter int FIXED_FRAME_BYTES = sld_pkg::FIXED_FRAME_BYTES_DEF,
  parameter int VAR_FRAME_MAX     = sld_pkg::VAR_FRAME_MAX_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [sld_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [sld_pkg::BYTE_W-1:0]    cfg_wdata,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [sld_pkg::ACT_W-1:0]     in_action,
  input  wire logic [sld_pkg::BYTE_W-1:0]    in_rx_byte,
  input  wire logic                          in_rx_error,
  input  wire logic [sld_pkg::IDX_W-1:0]     in_read_index,
  input  wire logic [sld_pkg::IDX_W-1:0]     in_dest_room,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [sld_pkg::BYTE_W-1:0]         out_byte,
  output logic [sld_pkg::LEN_W-1:0]          out_frame_length,
  output logic                               out_byte_ready_flag,
  output logic                               out_fixed_ready_flag,
  output logic                               out_var_ready_flag,
  output logic                               out_resync_flag,
  output logic                               out_error_flag,
  output logic                               out_release_done
);

  import sld_pkg::*;

  localparam int FAW = $clog2(2 * FIXED_FRAME_BYTES);
  localparam int VAW = $clog2(VAR_FRAME_MAX);

  cfg_t  cfg_r, cfg_nxt;
  logic  cfg_acc;
  logic  cfg_clr;
  res_t  res;

  logic              fx_we, fx_re, vr_we, vr_re;
  logic [FAW-1:0]    fx_waddr, fx_raddr;
  logic [VAW-1:0]    vr_waddr, vr_raddr;
  logic [BYTE_W-1:0] fx_rdata, vr_rdata;

  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign cfg_clr   = cfg_acc && cfg_index == REG_MODE;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_acc) begin
      unique case (cfg_index)
        REG_MODE:      cfg_nxt.mode      = cfg_wdata[MODE_W-1:0];
        REG_FIX_START: cfg_nxt.fix_start = cfg_wdata;
        REG_FIX_END:   cfg_nxt.fix_end   = cfg_wdata;
        REG_VAR_START: cfg_nxt.var_start = cfg_wdata;
        REG_VAR_END:   cfg_nxt.var_end   = cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode      <= MODE_SINGLE;
      cfg_r.fix_start <= '0;
      cfg_r.fix_end   <= '0;
      cfg_r.var_start <= '0;
      cfg_r.var_end   <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  sld_ctrl #(
    .FIXED_N (FIXED_FRAME_BYTES),
    .VAR_MAX (VAR_FRAME_MAX)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .cfg_clr       (cfg_clr),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_action     (in_action),
    .in_rx_byte    (in_rx_byte),
    .in_rx_error   (in_rx_error),
    .in_read_index (in_read_index),
    .in_dest_room  (in_dest_room),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .res           (res),
    .fx_we         (fx_we),
    .fx_waddr      (fx_waddr),
    .fx_re         (fx_re),
    .fx_raddr      (fx_raddr),
    .vr_we         (vr_we),
    .vr_waddr      (vr_waddr),
    .vr_re         (vr_re),
    .vr_raddr      (vr_raddr)
  );

  sld_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (2 * FIXED_FRAME_BYTES)
  ) u_fixed_ram (
    .clk   (clk),
    .we    (fx_we),
    .waddr (fx_waddr),
    .wdata (in_rx_byte),
    .re    (fx_re),
    .raddr (fx_raddr),
    .rdata (fx_rdata)
  );

  sld_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (VAR_FRAME_MAX)
  ) u_var_ram (
    .clk   (clk),
    .we    (vr_we),
    .waddr (vr_waddr),
    .wdata (in_rx_byte),
    .re    (vr_re),
    .raddr (vr_raddr),
    .rdata (vr_rdata)
  );

  always_comb begin
    unique case (res.sel)
      SEL_FIX: out_byte = fx_rdata;
      SEL_VAR: out_byte = vr_rdata;
      default: out_byte = res.data;
    endcase
  end

  assign out_frame_length     = res.frame_length;
  assign out_byte_ready_flag  = res.single_rdy;
  assign out_fixed_ready_flag = res.fixed_ready;
  assign out_var_ready_flag   = res.var_ready;
  assign out_resync_flag      = res.resync;
  assign out_error_flag       = res.error;
  assign out_release_done     = res.release_done;

endmodule
`default_nettype wire

// File: dv/deframer_checker.sv
// deframer checker: predicts the status of every accepted transaction and compares results
`timescale 1ns / 1ps
module deframer_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [sld_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sld_pkg::BYTE_W-1:0]    cfg_wdata,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [sld_pkg::ACT_W-1:0]     in_action,
  input  logic [sld_pkg::BYTE_W-1:0]    in_rx_byte,
  input  logic                          in_rx_error,
  input  logic [sld_pkg::IDX_W-1:0]     in_read_index,
  input  logic [sld_pkg::IDX_W-1:0]     in_dest_room,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [sld_pkg::BYTE_W-1:0]    out_byte,
  input  logic [sld_pkg::LEN_W-1:0]     out_frame_length,
  input  logic                          out_byte_ready_flag,
  input  logic                          out_fixed_ready_flag,
  input  logic                          out_var_ready_flag,
  input  logic                          out_resync_flag,
  input  logic                          out_error_flag,
  input  logic                          out_release_done,
  output int                            mismatch_count,
  output int                            status_left,
  output int                            var_written_len,
  output logic                          fixed_pub_seen
);

  import sld_pkg::*;

  localparam int FIX_N = FIXED_FRAME_BYTES_DEF;
  localparam int VAR_N = VAR_FRAME_MAX_DEF;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic [LEN_W-1:0]  frame_length;
    logic              single_rdy;
    logic              fixed_ready;
    logic              var_ready;
    logic              resync;
    logic              error;
    logic              release_done;
  } rx_status_t;

  logic [MODE_W-1:0] mode_q;
  logic [BYTE_W-1:0] fix_start_q, fix_end_q, var_start_q, var_end_q;
  int                fill_cnt;
  logic [BYTE_W-1:0] fix_cap [FIX_N];
  logic [BYTE_W-1:0] fix_pub [FIX_N];
  logic              fix_rdy, resyncing, err_pend, byte_rdy;
  logic [BYTE_W-1:0] latched;
  logic [BYTE_W-1:0] var_mem [VAR_N];
  int                var_cnt;
  logic              var_coll, var_rdy;
  int                var_depth;
  logic              pub_seen;

  rx_status_t status_due [$];

  task automatic clear_receive_state();
    fill_cnt  = 0;
    fix_rdy   = 1'b0;
    resyncing = 1'b0;
    err_pend  = 1'b0;
    byte_rdy  = 1'b0;
    var_cnt   = 0;
    var_coll  = 1'b0;
    var_rdy   = 1'b0;
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] wdata);
    case (idx)
      REG_MODE: begin
        mode_q = wdata[MODE_W-1:0];
        clear_receive_state();
      end
      REG_FIX_START: fix_start_q = wdata;
      REG_FIX_END:   fix_end_q   = wdata;
      REG_VAR_START: var_start_q = wdata;
      REG_VAR_END:   var_end_q   = wdata;
      default: ;
    endcase
  endtask

  task automatic update_receiver(input logic [ACT_W-1:0] act, input logic [BYTE_W-1:0] b,
                                 input logic err, input logic [IDX_W-1:0] idx,
                                 input logic [IDX_W-1:0] room, output rx_status_t st);
    logic [BYTE_W-1:0] rd;
    logic              done;
    int                len;
    rd   = '0;
    done = 1'b0;
    len  = 0;
    case (act)
      ACT_BYTE: begin
        case (mode_q)
          MODE_SINGLE: begin
            if (err) begin
              err_pend = 1'b1;
            end else begin
              latched  = b;
              byte_rdy = 1'b1;
            end
          end
          MODE_FIXED: begin
            if (resyncing) begin
              if (err) begin
                err_pend = 1'b1;
              end else if (b == fix_end_q) begin
                resyncing = 1'b0;
                err_pend  = 1'b0;
              end
            end else begin
              if (err) err_pend = 1'b1;
              if (fill_cnt >= FIX_N) fill_cnt = 0;
              fix_cap[fill_cnt] = b;
              fill_cnt++;
              if (fill_cnt >= FIX_N) begin
                fill_cnt = 0;
                if (!err_pend && fix_cap[0] == fix_start_q &&
                    fix_cap[FIX_N-1] == fix_end_q) begin
                  fix_pub  = fix_cap;
                  fix_rdy  = 1'b1;
                  pub_seen = 1'b1;
                end else begin
                  resyncing = 1'b1;
                end
                err_pend = 1'b0;
              end
            end
          end
          MODE_VAR: begin
            if (err) begin
              err_pend = 1'b1;
            end else if (!var_rdy) begin
              if (b == var_start_q) begin
                var_mem[0] = b;
                var_cnt    = 1;
                var_coll   = 1'b1;
                if (var_depth < 1) var_depth = 1;
              end else if (var_coll) begin
                if (var_cnt >= VAR_N) begin
                  var_cnt  = 0;
                  var_coll = 1'b0;
                end else begin
                  var_mem[var_cnt] = b;
                  var_cnt++;
                  if (var_depth < var_cnt) var_depth = var_cnt;
                  if (b == var_end_q) begin
                    var_rdy  = 1'b1;
                    var_coll = 1'b0;
                  end
                end
              end
            end
          end
          default: ;
        endcase
      end
      ACT_READ: begin
        if (mode_q == MODE_SINGLE) rd = latched;
        else if (mode_q == MODE_FIXED && idx < FIX_N) rd = fix_pub[idx];
        else if (mode_q == MODE_VAR && idx < VAR_N) rd = var_mem[idx];
      end
      ACT_RELEASE: begin
        if (mode_q == MODE_SINGLE && byte_rdy) begin
          byte_rdy = 1'b0;
          done     = 1'b1;
        end else if (mode_q == MODE_FIXED && fix_rdy) begin
          fix_rdy = 1'b0;
          done    = 1'b1;
        end else if (mode_q == MODE_VAR && var_rdy && var_cnt != 0 && var_cnt <= room) begin
          var_rdy = 1'b0;
          var_cnt = 0;
          done    = 1'b1;
        end
      end
      default: ;
    endcase
    if (mode_q == MODE_FIXED && fix_rdy) len = FIX_N;
    else if (mode_q == MODE_VAR && var_rdy) len = var_cnt;
    if (len > LEN_SAT) len = LEN_SAT;
    st.data         = rd;
    st.frame_length = len[LEN_W-1:0];
    st.single_rdy   = byte_rdy;
    st.fixed_ready  = fix_rdy;
    st.var_ready    = var_rdy;
    st.resync       = resyncing;
    st.error        = err_pend;
    st.release_done = done;
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    rx_status_t want;
    rx_status_t got;
    if (!rst_n) begin
      mode_q      = MODE_SINGLE;
      fix_start_q = '0;
      fix_end_q   = '0;
      var_start_q = '0;
      var_end_q   = '0;
      latched     = '0;
      var_depth   = 0;
      pub_seen    = 1'b0;
      clear_receive_state();
      status_due.delete();
      mismatch_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        got = {out_byte, out_frame_length, out_byte_ready_flag, out_fixed_ready_flag,
               out_var_ready_flag, out_resync_flag, out_error_flag, out_release_done};
        if (status_due.size() == 0) begin
          $display("%0t: result with no transaction outstanding: expected none, actual %h",
                   $time, got);
          mismatch_count++;
        end else begin
          want = status_due.pop_front();
          check_field("out_byte", int'(want.data), int'(got.data));
          check_field("out_frame_length", int'(want.frame_length), int'(got.frame_length));
          check_field("out_byte_ready_flag", int'(want.single_rdy), int'(got.single_rdy));
          check_field("out_fixed_ready_flag", int'(want.fixed_ready), int'(got.fixed_ready));
          check_field("out_var_ready_flag", int'(want.var_ready), int'(got.var_ready));
          check_field("out_resync_flag", int'(want.resync), int'(got.resync));
          check_field("out_error_flag", int'(want.error), int'(got.error));
          check_field("out_release_done", int'(want.release_done), int'(got.release_done));
        end
      end
      if (cfg_valid && cfg_ready) write_register(cfg_index, cfg_wdata);
      if (in_valid && in_ready) begin
        update_receiver(in_action, in_rx_byte, in_rx_error, in_read_index, in_dest_room, want);
        status_due.push_back(want);
      end
    end
    status_left     <= status_due.size();
    var_written_len <= var_depth;
    fixed_pub_seen  <= pub_seen;
  end

endmodule

// File: dv/tb_serial_link_receive_deframer.sv
// testbench top: reset, register phases, directed and random action stimulus, verdict
`timescale 1ns / 1ps
module tb_serial_link_receive_deframer;
  import sld_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [BYTE_W-1:0]    cfg_wdata;
  logic                 in_valid;
  logic                 in_ready;
  logic [ACT_W-1:0]     in_action;
  logic [BYTE_W-1:0]    in_rx_byte;
  logic                 in_rx_error;
  logic [IDX_W-1:0]     in_read_index;
  logic [IDX_W-1:0]     in_dest_room;
  logic                 out_valid;
  logic                 out_ready;
  logic [BYTE_W-1:0]    out_byte;
  logic [LEN_W-1:0]     out_frame_length;
  logic                 out_byte_ready_flag;
  logic                 out_fixed_ready_flag;
  logic                 out_var_ready_flag;
  logic                 out_resync_flag;
  logic                 out_error_flag;
  logic                 out_release_done;

  int                mismatch_count;
  int                status_left;
  int                var_written_len;
  logic              fixed_pub_seen;
  int                send_idle_pct = 0;
  int                stall_pct     = 0;
  int                counted_items = 0;
  logic [MODE_W-1:0] cur_mode      = MODE_SINGLE;
  logic [BYTE_W-1:0] fix_start_v   = '0;
  logic [BYTE_W-1:0] fix_end_v     = '0;
  logic [BYTE_W-1:0] var_start_v   = '0;
  logic [BYTE_W-1:0] var_end_v     = '0;

  always #10 clk = ~clk;

  always @(posedge clk) out_ready <= ($urandom_range(99) >= stall_pct);

  serial_link_receive_deframer u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_action            (in_action),
    .in_rx_byte           (in_rx_byte),
    .in_rx_error          (in_rx_error),
    .in_read_index        (in_read_index),
    .in_dest_room         (in_dest_room),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_byte             (out_byte),
    .out_frame_length     (out_frame_length),
    .out_byte_ready_flag  (out_byte_ready_flag),
    .out_fixed_ready_flag (out_fixed_ready_flag),
    .out_var_ready_flag   (out_var_ready_flag),
    .out_resync_flag      (out_resync_flag),
    .out_error_flag       (out_error_flag),
    .out_release_done     (out_release_done)
  );

  deframer_checker u_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_action            (in_action),
    .in_rx_byte           (in_rx_byte),
    .in_rx_error          (in_rx_error),
    .in_read_index        (in_read_index),
    .in_dest_room         (in_dest_room),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_byte             (out_byte),
    .out_frame_length     (out_frame_length),
    .out_byte_ready_flag  (out_byte_ready_flag),
    .out_fixed_ready_flag (out_fixed_ready_flag),
    .out_var_ready_flag   (out_var_ready_flag),
    .out_resync_flag      (out_resync_flag),
    .out_error_flag       (out_error_flag),
    .out_release_done     (out_release_done),
    .mismatch_count       (mismatch_count),
    .status_left          (status_left),
    .var_written_len      (var_written_len),
    .fixed_pub_seen       (fixed_pub_seen)
  );

  task automatic send_item(input logic [ACT_W-1:0] act, input logic [BYTE_W-1:0] b,
                           input logic err, input logic [IDX_W-1:0] idx,
                           input logic [IDX_W-1:0] room);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_action     <= act;
    in_rx_byte    <= b;
    in_rx_error   <= err;
    in_read_index <= idx;
    in_dest_room  <= room;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (cur_mode != MODE_OFF) counted_items++;
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic err);
    send_item(ACT_BYTE, b, err, IDX_W'($urandom_range(123)), IDX_W'($urandom_range(124)));
  endtask

  task automatic send_release(input logic [IDX_W-1:0] room);
    send_item(ACT_RELEASE, BYTE_W'($urandom_range(255)), 1'($urandom_range(1)),
              IDX_W'($urandom_range(123)), room);
  endtask

  // stored entries never written are not read
  function automatic int pick_read_index();
    case (cur_mode)
      MODE_FIXED: begin
        if (fixed_pub_seen && $urandom_range(3) != 0)
          return $urandom_range(FIXED_FRAME_BYTES_DEF - 1);
        return $urandom_range(123, FIXED_FRAME_BYTES_DEF);
      end
      MODE_VAR: begin
        if (var_written_len > 0) return $urandom_range(var_written_len - 1);
        return -1;
      end
      default: return $urandom_range(123);
    endcase
  endfunction

  task automatic send_read();
    int k;
    k = pick_read_index();
    if (k < 0) send_release(IDX_W'($urandom_range(124)));
    else send_item(ACT_READ, BYTE_W'($urandom_range(255)), 1'($urandom_range(1)),
                   k[IDX_W-1:0], IDX_W'($urandom_range(124)));
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (status_left != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] wdata);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= wdata;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_MODE:      cur_mode    = wdata[MODE_W-1:0];
      REG_FIX_START: fix_start_v = wdata;
      REG_FIX_END:   fix_end_v   = wdata;
      REG_VAR_START: var_start_v = wdata;
      REG_VAR_END:   var_end_v   = wdata;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_fixed_frame();
    int kind;
    int bad_pos;
    logic [BYTE_W-1:0] b;
    kind    = $urandom_range(7);
    bad_pos = $urandom_range(FIXED_FRAME_BYTES_DEF - 1);
    for (int k = 0; k < FIXED_FRAME_BYTES_DEF; k++) begin
      if (k == 0) begin
        b = fix_start_v;
        if (kind == 6) b = b ^ (8'd1 << $urandom_range(7));
      end else if (k == FIXED_FRAME_BYTES_DEF - 1) begin
        b = fix_end_v;
        if (kind == 7) b = b ^ (8'd1 << $urandom_range(7));
      end else begin
        b = BYTE_W'($urandom_range(255));
      end
      send_byte(b, kind == 5 && k == bad_pos);
    end
    if ($urandom_range(1) == 0) send_read();
  endtask

  task automatic send_var_frame();
    int n;
    int tail;
    logic [BYTE_W-1:0] b;
    n = ($urandom_range(7) == 0) ? $urandom_range(130, 118) : $urandom_range(16);
    send_byte(var_start_v, 1'b0);
    for (int k = 0; k < n; k++) begin
      b = BYTE_W'($urandom_range(255));
      if ((b == var_start_v || b == var_end_v) && $urandom_range(9) != 0) b = b ^ 8'h5a;
      send_byte(b, $urandom_range(49) == 0);
    end
    tail = $urandom_range(9);
    if (tail == 1) send_byte(var_end_v, 1'b1);
    else if (tail != 0) send_byte(var_end_v, 1'b0);
    if ($urandom_range(1) == 0) send_read();
    send_release(($urandom_range(1) == 0) ? 7'd124 : 7'($urandom_range(124)));
  endtask

  initial begin
    int r;
    int target;
    logic [MODE_W-1:0] next_mode;
    rst_n         <= 1'b0;
    cfg_valid     <= 1'b0;
    cfg_index     <= '0;
    cfg_wdata     <= '0;
    in_valid      <= 1'b0;
    in_action     <= ACT_BYTE;
    in_rx_byte    <= '0;
    in_rx_error   <= 1'b0;
    in_read_index <= '0;
    in_dest_room  <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single byte mode out of reset
    send_item(ACT_READ, 8'h00, 1'b0, 7'd0, 7'd0);
    send_release(7'd0);
    send_byte(8'hff, 1'b0);
    send_item(ACT_READ, 8'h00, 1'b1, 7'd123, 7'd124);
    send_byte(8'h00, 1'b1);
    send_release(7'd124);
    send_release(7'd124);

    settle();
    write_reg(REG_UNUSED, 8'hff);
    write_reg(REG_VAR_START, 8'h00);
    write_reg(REG_VAR_END, 8'hff);
    write_reg(REG_MODE, {6'd0, MODE_VAR});
    send_byte(8'h00, 1'b0);
    send_byte(8'h41, 1'b1);
    send_byte(8'h41, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b0);
    send_item(ACT_READ, 8'h00, 1'b0, 7'd2, 7'd0);
    send_release(7'd2);
    send_release(7'd3);

    settle();
    write_reg(REG_MODE, {6'd0, MODE_OFF});
    send_byte(8'ha5, 1'b1);
    send_item(ACT_READ, 8'hff, 1'b1, 7'd5, 7'd124);
    send_release(7'd124);

    for (int p = 0; p < 20; p++) begin
      settle();
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 47; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 47; end
        default: begin send_idle_pct = 29; stall_pct = 29; end
      endcase
      case (p % 5)
        0, 3:    next_mode = MODE_FIXED;
        1, 4:    next_mode = MODE_VAR;
        default: next_mode = MODE_SINGLE;
      endcase
      case (p)
        0: begin write_reg(REG_FIX_START, 8'h00); write_reg(REG_FIX_END, 8'hff); end
        3: begin write_reg(REG_FIX_START, 8'hff); write_reg(REG_FIX_END, 8'h00); end
        8: begin
          r = $urandom_range(255);
          write_reg(REG_FIX_START, r[7:0]);
          write_reg(REG_FIX_END, r[7:0]);
        end
        default: begin
          write_reg(REG_FIX_START, BYTE_W'($urandom_range(255)));
          write_reg(REG_FIX_END, BYTE_W'($urandom_range(255)));
        end
      endcase
      case (p)
        1: begin write_reg(REG_VAR_START, 8'h00); write_reg(REG_VAR_END, 8'hff); end
        4: begin write_reg(REG_VAR_START, 8'hff); write_reg(REG_VAR_END, 8'h00); end
        9: begin
          r = $urandom_range(255);
          write_reg(REG_VAR_START, r[7:0]);
          write_reg(REG_VAR_END, r[7:0]);
        end
        default: begin
          write_reg(REG_VAR_START, BYTE_W'($urandom_range(255)));
          write_reg(REG_VAR_END, BYTE_W'($urandom_range(255)));
        end
      endcase
      write_reg(REG_MODE, {6'd0, next_mode});
      target = counted_items + 85;
      while (counted_items < target) begin
        r = $urandom_range(99);
        case (cur_mode)
          MODE_FIXED: begin
            if (r < 70) send_fixed_frame();
            else if (r < 80) send_read();
            else if (r < 90) send_release(IDX_W'($urandom_range(124)));
            else send_byte(BYTE_W'($urandom_range(255)), $urandom_range(4) == 0);
          end
          MODE_VAR: begin
            if (r < 65) send_var_frame();
            else if (r < 80) send_read();
            else if (r < 92) send_release(IDX_W'($urandom_range(124)));
            else send_byte(BYTE_W'($urandom_range(255)), $urandom_range(4) == 0);
          end
          default: begin
            if (r < 55) send_byte(BYTE_W'($urandom_range(255)), $urandom_range(9) == 0);
            else if (r < 78) send_read();
            else send_release(IDX_W'($urandom_range(124)));
          end
        endcase
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    for (int w = 0; w < 20000 && status_left != 0; w++) @(posedge clk);
    repeat (5) @(posedge clk);
    if (mismatch_count == 0 && status_left == 0) begin
      $display("Testbench completed without errors");
    end else begin
      if (status_left != 0) $display("%0t: %0d expected results never arrived", $time, status_left);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("%0t: timeout", $time);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
